// ----- design/ncc_pkg.sv -----
`default_nettype none

package ncc_pkg;

  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_MAX_DISP  = 256;
  localparam int DEF_MAX_WIN   = 15;
  localparam int MAX_ROWS      = 2048;

  localparam int CFG_DATA_W = 12;
  localparam int ROW_W      = 11;
  localparam int HEIGHT_W   = 12;

  localparam logic [11:0] RST_WIDTH  = 12'd640;
  localparam logic [11:0] RST_HEIGHT = 12'd480;
  localparam logic [8:0]  RST_DISP   = 9'd256;
  localparam logic [3:0]  RST_WIN    = 4'd3;

  localparam int FRAC_BITS   = 15;
  localparam int QUOT_W      = 17;
  localparam int COST_W      = 16;

  typedef logic signed [COST_W-1:0] cost_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_DISP   = 2'd2,
    REG_WIN    = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

// ----- design/ncc_line_store.sv -----
`default_nettype none

module ncc_line_store #(
  parameter int MAX_WIN   = ncc_pkg::DEF_MAX_WIN,
  parameter int MAX_WIDTH = ncc_pkg::DEF_MAX_WIDTH,
  parameter int SLW       = 4,
  parameter int CW        = 11
) (
  input  wire logic           clk,
  input  wire logic           wr_en,
  input  wire logic [SLW-1:0] wr_slot,
  input  wire logic [CW-1:0]  wr_col,
  input  wire logic [7:0]     wr_left,
  input  wire logic [7:0]     wr_right,
  input  wire logic [SLW-1:0] rd_slot,
  input  wire logic [CW-1:0]  rd_col_left,
  input  wire logic [CW-1:0]  rd_col_right,
  output logic      [7:0]     rd_left,
  output logic      [7:0]     rd_right
);

  logic [7:0] left_mem  [MAX_WIN][MAX_WIDTH];
  logic [7:0] right_mem [MAX_WIN][MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      left_mem[wr_slot][wr_col]  <= wr_left;
      right_mem[wr_slot][wr_col] <= wr_right;
    end
    rd_left  <= left_mem[rd_slot][rd_col_left];
    rd_right <= right_mem[rd_slot][rd_col_right];
  end

endmodule

`default_nettype wire

// ----- design/ncc_cost_unit.sv -----
`default_nettype none

module ncc_cost_unit #(
  parameter int NUMW = 34,
  parameter int RW   = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic signed [NUMW-1:0]              num,
  input  wire logic        [2*RW-1:0]              prod,
  output logic                                     done,
  output ncc_pkg::cost_t                           cost
);

  localparam int PW   = 2 * RW;
  localparam int QW   = ncc_pkg::QUOT_W;
  localparam int DIVW = NUMW + ncc_pkg::FRAC_BITS + 1;
  localparam int HIW  = DIVW - QW;

  typedef enum logic [4:0] {
    C_IDLE = 5'b00001,
    C_SQRT = 5'b00010,
    C_PREP = 5'b00100,
    C_DIV  = 5'b01000,
    C_FIN  = 5'b10000
  } cstate_t;

  cstate_t          cst;
  logic [5:0]       cnt;
  logic [PW-1:0]    v;
  logic [PW-1:0]    res;
  logic [PW-1:0]    bitm;
  logic [PW-1:0]    trial;
  logic [NUMW-1:0]  mag;
  logic             num_pos;
  logic [RW-1:0]    root;
  logic [DIVW-1:0]  dividend;
  logic [HIW-1:0]   hi;
  logic [RW-1:0]    rem;
  logic [RW:0]      rem2;
  logic [QW-1:0]    low;
  logic [QW-1:0]    quo;
  ncc_pkg::cost_t   sat_cost;
  ncc_pkg::cost_t   fin_cost;

  always_comb begin
    trial    = res + bitm;
    root     = res[RW-1:0];
    dividend = (DIVW'(mag) << ncc_pkg::FRAC_BITS) + DIVW'(root >> 1);
    hi       = dividend[DIVW-1:QW];
    rem2     = {rem, low[QW-1]};
    sat_cost = num_pos ? ncc_pkg::cost_t'(16'sh8000) : ncc_pkg::cost_t'(16'sh7fff);
    if (num_pos) begin
      fin_cost = (quo > QW'(32768)) ? ncc_pkg::cost_t'(16'sh8000)
                                    : ncc_pkg::cost_t'(-$signed({1'b0, quo}));
    end else begin
      fin_cost = (quo > QW'(32767)) ? ncc_pkg::cost_t'(16'sh7fff)
                                    : ncc_pkg::cost_t'(quo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cst  <= C_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (cst)
        C_IDLE: begin
          if (start) begin
            cst <= C_SQRT;
          end
        end
        C_SQRT: begin
          if (cnt == 6'(RW - 1)) begin
            cst <= C_PREP;
          end
        end
        C_PREP: begin
          if (root == '0 || HIW'(hi) >= HIW'(root) && (HIW >= RW || hi >= HIW'(root))) begin
            cst  <= C_IDLE;
            done <= 1'b1;
          end else begin
            cst <= C_DIV;
          end
        end
        C_DIV: begin
          if (cnt == 6'(QW - 1)) begin
            cst <= C_FIN;
          end
        end
        C_FIN: begin
          cst  <= C_IDLE;
          done <= 1'b1;
        end
        default: cst <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cst)
      C_IDLE: begin
        v       <= prod;
        res     <= '0;
        bitm    <= PW'(1) << (PW - 2);
        cnt     <= '0;
        num_pos <= (num > 0);
        mag     <= (num < 0) ? NUMW'(-num) : NUMW'(num);
      end
      C_SQRT: begin
        if (v >= trial) begin
          v   <= v - trial;
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
        cnt  <= cnt + 6'd1;
      end
      C_PREP: begin
        rem  <= RW'(hi);
        low  <= dividend[QW-1:0];
        quo  <= '0;
        cnt  <= '0;
        if (root == '0) begin
          cost <= '0;
        end else begin
          cost <= sat_cost;
        end
      end
      C_DIV: begin
        if (rem2 >= {1'b0, root}) begin
          rem <= RW'(rem2 - {1'b0, root});
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          rem <= rem2[RW-1:0];
          quo <= {quo[QW-2:0], 1'b0};
        end
        low <= low << 1;
        cnt <= cnt + 6'd1;
      end
      C_FIN: begin
        cost <= fin_cost;
      end
      default: begin
        cnt <= '0;
      end
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> cst == C_IDLE) else $error("cost unit started while busy");

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cst == C_PREP) || $past(cst == C_FIN))
    else $error("cost done without a finishing step");

endmodule

`default_nettype wire

// ----- design/ncc_stereo_disparity.sv -----
// ncc stereo disparity, block matching by normalized cross-correlation
//
// s_tdata carries one left/right pixel pair per transaction in raster order.
// m_tdata carries one result per complete window: centre row and column, the
// winning disparity and its cost as signed Q1.15; m_tlast marks the result of
// the last pixel of the frame. Pixels that complete no window give no result.
// The cfg port writes image width, height, disparity count and window size
// (indices 0 to 3); write it only while the block is idle.
// A pixel that completes no window leaves the block idle for the next pixel.
// A window is scored at m = min(disparity_count, j + 1) disparities, j being
// its left column: each disparity walks the window through the line stores
// at one pixel pair a cycle, then runs a 32-step square root and, unless the
// cost is zero or saturates, a 17-step division in the shared cost unit.
// Reset clears the row and column position and loads the default register
// values; the memories are not cleared. The result waits in an output
// register while m_tready is low; the next pixel is taken meanwhile, and the
// block stalls only when a new result finds that register still full.
`default_nettype none

module ncc_stereo_disparity #(
  parameter int MAX_WIDTH = ncc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_DISP  = ncc_pkg::DEF_MAX_DISP,
  parameter int MAX_WIN   = ncc_pkg::DEF_MAX_WIN
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [15:0]                       s_tdata,  // left_pixel, right_pixel
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // center_row, center_col, disparity, best_cost
  output logic [47:0]                            m_tdata,
  output logic                                   m_tlast,  // frame_done
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [ncc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int SLW  = (MAX_WIN > 1) ? $clog2(MAX_WIN) : 1;
  localparam int WSW  = $clog2(MAX_WIN + 1);
  localparam int DW   = $clog2(MAX_DISP + 1);
  localparam int NW   = $clog2(MAX_WIN * MAX_WIN + 1);
  localparam int SUMW = NW + 8;
  localparam int QW   = NW + 16;
  localparam int VARW = NW + QW;
  localparam int SSW  = SUMW + SUMW;
  localparam int NUMW = ((VARW > SSW) ? VARW : SSW) + 1;
  localparam int SW   = SUMW;
  localparam int VW   = VARW;
  localparam int RW   = ncc_pkg::ROW_W;
  localparam int HW   = ncc_pkg::HEIGHT_W;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_WALK  = 10'b0000000010,
    ST_DRAIN = 10'b0000000100,
    ST_VAR   = 10'b0000001000,
    ST_VAR2  = 10'b0000010000,
    ST_RDMEM = 10'b0000100000,
    ST_NUM   = 10'b0001000000,
    ST_COST  = 10'b0010000000,
    ST_CWAIT = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

  // configuration
  logic [11:0]    cfg_width;
  logic [11:0]    cfg_height;
  logic [8:0]     cfg_disp;
  logic [3:0]     cfg_win;
  logic [WW-1:0]  w_use;
  logic [HW-1:0]  h_use;
  logic [DW-1:0]  nd_use;
  logic [WSW-1:0] ws_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= ncc_pkg::RST_WIDTH;
      cfg_height <= ncc_pkg::RST_HEIGHT;
      cfg_disp   <= ncc_pkg::RST_DISP;
      cfg_win    <= ncc_pkg::RST_WIN;
    end else if (cfg_we) begin
      case (ncc_pkg::cfg_reg_t'(cfg_index))
        ncc_pkg::REG_WIDTH:  cfg_width  <= cfg_data;
        ncc_pkg::REG_HEIGHT: cfg_height <= cfg_data;
        ncc_pkg::REG_DISP:   cfg_disp   <= cfg_data[8:0];
        ncc_pkg::REG_WIN:    cfg_win    <= cfg_data[3:0];
        default:             cfg_win    <= cfg_win;
      endcase
    end
  end

  always_comb begin
    if (cfg_width == '0)            w_use = WW'(1);
    else if (cfg_width > MAX_WIDTH) w_use = WW'(MAX_WIDTH);
    else                            w_use = WW'(cfg_width);
    if (cfg_height == '0)                    h_use = HW'(1);
    else if (cfg_height > ncc_pkg::MAX_ROWS) h_use = HW'(ncc_pkg::MAX_ROWS);
    else                                     h_use = HW'(cfg_height);
    if (cfg_disp == '0)           nd_use = DW'(1);
    else if (cfg_disp > MAX_DISP) nd_use = DW'(MAX_DISP);
    else                          nd_use = DW'(cfg_disp);
    if (cfg_win == '0)          ws_use = WSW'(1);
    else if (cfg_win > MAX_WIN) ws_use = WSW'(MAX_WIN);
    else                        ws_use = WSW'(cfg_win);
  end

  function automatic logic [SLW-1:0] slot_inc(input logic [SLW-1:0] s);
    logic [SLW:0] t;
    t = {1'b0, s} + (SLW+1)'(1);
    return (t == (SLW+1)'(MAX_WIN)) ? '0 : SLW'(t);
  endfunction

  // position and control
  state_t           state;
  logic [RW-1:0]    row_cnt;
  logic [CW-1:0]    col_cnt;
  logic [SLW-1:0]   slot_cnt;
  logic [RW-1:0]    i_reg;
  logic [CW-1:0]    j_reg;
  logic [CW-1:0]    jr_reg;
  logic [SLW-1:0]   si_reg;
  logic             last_reg;
  logic [WSW-1:0]   a_cnt;
  logic [WSW-1:0]   b_cnt;
  logic [SLW-1:0]   sa;
  logic [DW-1:0]    d_cnt;
  logic             stats_walk;
  logic             rd_v;

  logic             accept;
  logic             wrap_c;
  logic [HW-1:0]    row_a;
  logic [SLW-1:0]   slot_a;
  logic [RW-1:0]    cur_r;
  logic [CW-1:0]    cur_c;
  logic [CW:0]      col_p;
  logic [HW-1:0]    row_p;
  logic [SLW-1:0]   slot_p;
  logic [CW-1:0]    col_next;
  logic             win;
  logic             frame_last;
  int               si_tmp;
  logic [SLW-1:0]   si_a;
  logic [CW:0]      j1;
  logic [DW-1:0]    m_val;
  logic             walk_last;
  logic             more_d;
  logic             clr_acc;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    wrap_c = ({1'b0, col_cnt} >= (CW+1)'(w_use));
    row_a  = {1'b0, row_cnt} + HW'(wrap_c);
    slot_a = wrap_c ? slot_inc(slot_cnt) : slot_cnt;
    if (row_a >= h_use) begin
      row_a  = '0;
      slot_a = '0;
    end
    cur_r = row_a[RW-1:0];
    cur_c = wrap_c ? '0 : col_cnt;
    col_p = {1'b0, cur_c} + (CW+1)'(1);
    if (col_p >= (CW+1)'(w_use)) begin
      col_next = '0;
      row_p    = {1'b0, cur_r} + HW'(1);
      slot_p   = slot_inc(slot_a);
      if (row_p >= h_use) begin
        row_p  = '0;
        slot_p = '0;
      end
    end else begin
      col_next = CW'(col_p);
      row_p    = {1'b0, cur_r};
      slot_p   = slot_a;
    end
    win = ({1'b0, cur_r} + HW'(1) >= HW'(ws_use)) && (col_p >= (CW+1)'(ws_use));
    frame_last = ({1'b0, cur_r} + HW'(1) == h_use) && (col_p == (CW+1)'(w_use));
    si_tmp = int'(slot_a) - int'(ws_use) + 1;
    if (si_tmp < 0) begin
      si_tmp = si_tmp + MAX_WIN;
    end
    si_a = SLW'(si_tmp);
    j1    = {1'b0, j_reg} + (CW+1)'(1);
    m_val = (j1 < (CW+1)'(nd_use)) ? DW'(j1) : nd_use;
    walk_last = (a_cnt == ws_use - WSW'(1)) && (b_cnt == ws_use - WSW'(1));
  end

  // line stores
  logic [7:0] lq;
  logic [7:0] rq;

  ncc_line_store #(
    .MAX_WIN   (MAX_WIN),
    .MAX_WIDTH (MAX_WIDTH),
    .SLW       (SLW),
    .CW        (CW)
  ) u_line_store (
    .clk          (clk),
    .wr_en        (accept),
    .wr_slot      (slot_a),
    .wr_col       (cur_c),
    .wr_left      (s_tdata[7:0]),
    .wr_right     (s_tdata[15:8]),
    .rd_slot      (sa),
    .rd_col_left  (j_reg + CW'(b_cnt)),
    .rd_col_right (jr_reg + CW'(b_cnt)),
    .rd_left      (lq),
    .rd_right     (rq)
  );

  // window accumulators
  logic [NW-1:0]   n_val;
  logic [SUMW-1:0] sum_l;
  logic [SUMW-1:0] sum_r;
  logic [QW-1:0]   sq_l;
  logic [QW-1:0]   sq_r;
  logic [QW-1:0]   dot;

  assign n_val = NW'(ws_use * ws_use);

  always_ff @(posedge clk) begin
    if (clr_acc) begin
      sum_l <= '0;
      sum_r <= '0;
      sq_l  <= '0;
      sq_r  <= '0;
      dot   <= '0;
    end else if (rd_v) begin
      sum_l <= sum_l + SUMW'(lq);
      sum_r <= sum_r + SUMW'(rq);
      sq_l  <= sq_l + QW'(lq * lq);
      sq_r  <= sq_r + QW'(rq * rq);
      dot   <= dot + QW'(lq * rq);
    end
  end

  // per-column right sums and scale terms
  logic [VW+SW-1:0] col_mem [MAX_WIDTH];
  logic [VW+SW-1:0] cm_q;
  logic [VARW-1:0]  nq_l;
  logic [VARW-1:0]  ss_l;
  logic [VARW-1:0]  nq_r;
  logic [VARW-1:0]  ss_r;
  logic [VARW-1:0]  var_l;
  logic [VARW-1:0]  var_r;
  logic [VARW-1:0]  prod_nd;
  logic [SSW-1:0]   prod_ss;
  logic [2*VARW-1:0]      prod_p;
  logic signed [NUMW-1:0] num_val;

  assign var_r   = nq_r - ss_r;
  assign num_val = $signed(NUMW'(prod_nd)) - $signed(NUMW'(prod_ss));

  always_ff @(posedge clk) begin
    if (state == ST_VAR2) begin
      col_mem[j_reg] <= {VW'(var_r), SW'(sum_r)};
    end
    cm_q <= col_mem[jr_reg];
  end

  always_ff @(posedge clk) begin
    if (state == ST_VAR) begin
      nq_l <= VARW'(n_val * sq_l);
      ss_l <= VARW'(sum_l * sum_l);
      nq_r <= VARW'(n_val * sq_r);
      ss_r <= VARW'(sum_r * sum_r);
    end
    if (state == ST_VAR2) begin
      var_l <= nq_l - ss_l;
    end
    if (state == ST_NUM) begin
      prod_nd <= VARW'(n_val * dot);
      prod_ss <= SSW'(sum_l * cm_q[SW-1:0]);
      prod_p  <= (2*VARW)'(var_l * cm_q[VW+SW-1:SW]);
    end
  end

  // cost
  logic           cost_done;
  ncc_pkg::cost_t cost;
  ncc_pkg::cost_t best;
  logic [DW-1:0]  best_d;

  ncc_cost_unit #(
    .NUMW (NUMW),
    .RW   (VARW)
  ) u_cost (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_COST),
    .num   (num_val),
    .prod  (prod_p),
    .done  (cost_done),
    .cost  (cost)
  );

  assign more_d  = ({1'b0, d_cnt} + (DW+1)'(1)) < (DW+1)'(m_val);
  assign clr_acc = (accept && win) || (state == ST_CWAIT && cost_done && more_d);

  // control
  logic           out_free;
  logic           zero_fill;
  ncc_pkg::cost_t cost_fin;
  logic [DW-1:0]  disp_fin;

  assign out_free  = !m_tvalid || m_tready;
  assign zero_fill = (m_val < nd_use) && (best > 0);
  assign cost_fin  = zero_fill ? '0 : best;
  assign disp_fin  = zero_fill ? m_val : best_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      row_cnt  <= '0;
      col_cnt  <= '0;
      slot_cnt <= '0;
      rd_v     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_v <= (state == ST_WALK);
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            row_cnt  <= RW'(row_p);
            col_cnt  <= col_next;
            slot_cnt <= slot_p;
            if (win) begin
              state <= ST_WALK;
            end
          end
        end
        ST_WALK: begin
          if (walk_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: state <= stats_walk ? ST_VAR : ST_RDMEM;
        ST_VAR:   state <= ST_VAR2;
        ST_VAR2:  state <= ST_RDMEM;
        ST_RDMEM: state <= ST_NUM;
        ST_NUM:   state <= ST_COST;
        ST_COST:  state <= ST_CWAIT;
        ST_CWAIT: begin
          if (cost_done) begin
            state <= more_d ? ST_WALK : ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && win) begin
      i_reg      <= RW'({1'b0, cur_r} + HW'(1) - HW'(ws_use));
      j_reg      <= CW'(col_p - (CW+1)'(ws_use));
      jr_reg     <= CW'(col_p - (CW+1)'(ws_use));
      si_reg     <= si_a;
      sa         <= si_a;
      last_reg   <= frame_last;
      a_cnt      <= '0;
      b_cnt      <= '0;
      d_cnt      <= '0;
      stats_walk <= 1'b1;
    end
    if (state == ST_WALK) begin
      if (b_cnt == ws_use - WSW'(1)) begin
        b_cnt <= '0;
        a_cnt <= a_cnt + WSW'(1);
        sa    <= slot_inc(sa);
      end else begin
        b_cnt <= b_cnt + WSW'(1);
      end
    end
    if (state == ST_CWAIT && cost_done) begin
      if (d_cnt == '0 || cost < best) begin
        best   <= cost;
        best_d <= d_cnt;
      end
      if (more_d) begin
        d_cnt      <= d_cnt + DW'(1);
        jr_reg     <= jr_reg - CW'(1);
        a_cnt      <= '0;
        b_cnt      <= '0;
        sa         <= si_reg;
        stats_walk <= 1'b0;
      end
    end
    if (state == ST_OUT && out_free) begin
      m_tdata <= {2'b00, cost_fin, 8'(disp_fin),
                  11'({1'b0, j_reg} + (CW+1)'(ws_use >> 1)),
                  11'(i_reg + RW'(ws_use >> 1))};
      m_tlast <= last_reg;
    end
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    cost_done |-> state == ST_CWAIT) else $error("cost result outside wait state");

  a_out_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_OUT))
    else $error("result raised outside output state");

  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> a_cnt < ws_use && b_cnt < ws_use && d_cnt < m_val)
    else $error("window walk out of range");

endmodule

`default_nettype wire
